FILE: sv/bfau_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and a helper function for the GF(2^m) arithmetic unit.
// No dependencies.
package bfau_pkg;

    localparam int FIELD_DEGREE = 256;
    localparam int FIELD_WORDS  = 4;
    localparam int WORD_W       = 64;
    localparam int IDX_W        = 2;
    localparam int MOD_REGS     = 4;
    localparam int CNT_W        = $clog2(FIELD_DEGREE);
    localparam int FLAT_W       = FIELD_WORDS * WORD_W;
    localparam int MOD_W        = MOD_REGS * WORD_W;
    localparam logic [WORD_W-1:0] MOD_RESET0 = 64'd1061;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_MUL,
        OP_SQR,
        OP_INV
    } t_op;

    typedef enum logic [1:0] {
        SRC_A,
        SRC_B,
        SRC_P,
        SRC_R
    } t_src;

    typedef enum logic {
        DST_P,
        DST_R
    } t_dst;

    typedef struct packed {
        logic load_add;
        logic init_inv;
        logic start;
        t_src x_sel;
        t_src y_sel;
        t_dst dst;
    } t_cmd;

    // Bits of operand word w that lie below the field degree.
    function automatic logic [WORD_W-1:0] word_mask(input logic [IDX_W-1:0] w);
        int base;
        base = WORD_W * int'(w);
        if (base >= FIELD_DEGREE) begin
            return '0;
        end else if (FIELD_DEGREE - base >= WORD_W) begin
            return '1;
        end else begin
            return (64'd1 << (FIELD_DEGREE - base)) - 64'd1;
        end
    endfunction

endpackage

FILE: sv/binary_field_arithmetic_unit.sv
`timescale 1ns / 1ps
// A non-last word only fills the operand stores. Add forms its result from the stores,
// passes through the wait state and then outputs it; multiply and square run the multiplier
// once. The bit-serial multiplier does one bit per cycle; inversion
// runs m-1 square-and-multiply rounds on it. One operation is in flight at a time.
// Results leave as FIELD_WORDS transactions, one word per cycle when taken.
// Reset (synchronous, active low) idles the unit and restores the modulus to x^256+x^10+x^5+x^2+1.
module binary_field_arithmetic_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [bfau_pkg::WORD_W-1:0]   i_cfg_data,
    // Operand channel.
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_opcode,
    input  logic [bfau_pkg::IDX_W-1:0]    i_word_index,
    input  logic [bfau_pkg::WORD_W-1:0]   i_a_word,
    input  logic [bfau_pkg::WORD_W-1:0]   i_b_word,
    input  logic                          i_last_word,
    // Result channel.
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bfau_pkg::IDX_W-1:0]    o_result_index,
    output logic [bfau_pkg::WORD_W-1:0]   o_result_word,
    output logic                          o_result_last
);

    bfau_pkg::t_cmd cmd;
    logic           done;
    logic           store;

    // Every accepted transaction writes its operand words into the stores.
    assign store = i_valid && o_ready;

    // The controller only advances on transactions whose last flag is set.
    bfau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_last_word (i_last_word),
        .i_done      (done),
        .o_cmd       (cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_idx   (o_result_index),
        .o_last      (o_result_last)
    );

    bfau_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_store       (store),
        .i_word_index  (i_word_index),
        .i_a_word      (i_a_word),
        .i_b_word      (i_b_word),
        .i_cmd         (cmd),
        .i_out_idx     (o_result_index),
        .o_done        (done),
        .o_result_word (o_result_word)
    );

    // The unit never takes operands while results are being delivered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("operand accepted during result output");

    // The last flag marks exactly the top result word.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result_last ==
            (o_result_index == bfau_pkg::IDX_W'(bfau_pkg::FIELD_WORDS - 1))))
        else $error("result last flag mismatch");

    // After the final result word is taken the unit returns to idle.
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_result_last) |=> (!o_valid && o_ready))
        else $error("unit not idle after final result");

    // The multiplier never reports completion while operands are being loaded.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> !o_ready) else $error("multiplier done while idle");

endmodule

FILE: sv/bfau_datapath.sv
`timescale 1ns / 1ps
// Datapath: operand stores, modulus registers, result registers and a
// bit-serial interleaved modular multiplier. Depends on bfau_pkg.
module bfau_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [bfau_pkg::WORD_W-1:0]         i_cfg_data,
    input  logic                                i_store,
    input  logic [bfau_pkg::IDX_W-1:0]          i_word_index,
    input  logic [bfau_pkg::WORD_W-1:0]         i_a_word,
    input  logic [bfau_pkg::WORD_W-1:0]         i_b_word,
    input  bfau_pkg::t_cmd                      i_cmd,
    input  logic [bfau_pkg::IDX_W-1:0]          i_out_idx,
    output logic                                o_done,
    output logic [bfau_pkg::WORD_W-1:0]         o_result_word
);

    logic [bfau_pkg::FIELD_WORDS-1:0][bfau_pkg::WORD_W-1:0] r_a_st;
    logic [bfau_pkg::FIELD_WORDS-1:0][bfau_pkg::WORD_W-1:0] r_b_st;
    logic [bfau_pkg::MOD_REGS-1:0][bfau_pkg::WORD_W-1:0]    r_mod;
    logic [bfau_pkg::FIELD_DEGREE-1:0] r_p;
    logic [bfau_pkg::FIELD_DEGREE-1:0] r_r;
    logic [bfau_pkg::FIELD_DEGREE-1:0] r_mx;
    logic [bfau_pkg::FIELD_DEGREE-1:0] r_my;
    logic [bfau_pkg::FIELD_DEGREE-1:0] r_acc;
    logic [bfau_pkg::CNT_W-1:0]        r_cnt;
    logic                              r_busy;
    logic                              r_done;
    bfau_pkg::t_dst                    r_dst;

    logic [bfau_pkg::FIELD_DEGREE-1:0] a_val;
    logic [bfau_pkg::FIELD_DEGREE-1:0] b_val;
    logic [bfau_pkg::FIELD_DEGREE-1:0] poly_low;
    logic [bfau_pkg::FIELD_DEGREE-1:0] n_acc;
    logic [bfau_pkg::FLAT_W-1:0]       result_flat;
    logic [bfau_pkg::FLAT_W-1:0]       a_flat;
    logic [bfau_pkg::FLAT_W-1:0]       b_flat;
    logic [bfau_pkg::MOD_W-1:0]        mod_flat;

    function automatic logic [bfau_pkg::FIELD_DEGREE-1:0] pick(
        input bfau_pkg::t_src s,
        input logic [bfau_pkg::FIELD_DEGREE-1:0] a,
        input logic [bfau_pkg::FIELD_DEGREE-1:0] b,
        input logic [bfau_pkg::FIELD_DEGREE-1:0] p,
        input logic [bfau_pkg::FIELD_DEGREE-1:0] r
    );
        case (s)
            bfau_pkg::SRC_A: return a;
            bfau_pkg::SRC_B: return b;
            bfau_pkg::SRC_P: return p;
            default:         return r;
        endcase
    endfunction

    assign a_flat   = r_a_st;
    assign b_flat   = r_b_st;
    assign mod_flat = r_mod;
    assign a_val    = a_flat[bfau_pkg::FIELD_DEGREE-1:0];
    assign b_val    = b_flat[bfau_pkg::FIELD_DEGREE-1:0];
    assign poly_low = mod_flat[bfau_pkg::FIELD_DEGREE-1:0];

    // One MSB-first step: multiply the partial result by x, reduce, add y if the top bit of x is set.
    always_comb begin
        n_acc = {r_acc[bfau_pkg::FIELD_DEGREE-2:0], 1'b0};
        if (r_acc[bfau_pkg::FIELD_DEGREE-1]) begin
            n_acc = n_acc ^ poly_low;
        end
        if (r_mx[bfau_pkg::FIELD_DEGREE-1]) begin
            n_acc = n_acc ^ r_my;
        end
    end

    assign result_flat   = bfau_pkg::FLAT_W'(r_r);
    assign o_result_word = result_flat[i_out_idx*bfau_pkg::WORD_W +: bfau_pkg::WORD_W];
    assign o_done        = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= bfau_pkg::MOD_W'(bfau_pkg::MOD_RESET0);
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_r    <= '0;
            r_p    <= '0;
        end else begin
            // Completion is flagged for one cycle after the final multiplier step.
            r_done <= r_busy && !i_cmd.start && (r_cnt == '0);
            if (i_cfg_we) begin
                r_mod[i_cfg_idx] <= i_cfg_data;
            end
            if (i_store && (int'(i_word_index) < bfau_pkg::FIELD_WORDS)) begin
                r_a_st[i_word_index] <= i_a_word & bfau_pkg::word_mask(i_word_index);
                r_b_st[i_word_index] <= i_b_word & bfau_pkg::word_mask(i_word_index);
            end
            if (i_cmd.load_add) begin
                r_r <= a_val ^ b_val;
            end
            if (i_cmd.init_inv) begin
                r_p <= a_val;
                r_r <= bfau_pkg::FIELD_DEGREE'(1);
            end
            if (i_cmd.start) begin
                r_mx   <= pick(i_cmd.x_sel, a_val, b_val, r_p, r_r);
                r_my   <= pick(i_cmd.y_sel, a_val, b_val, r_p, r_r);
                r_acc  <= '0;
                r_cnt  <= bfau_pkg::CNT_W'(bfau_pkg::FIELD_DEGREE - 1);
                r_dst  <= i_cmd.dst;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_mx  <= {r_mx[bfau_pkg::FIELD_DEGREE-2:0], 1'b0};
                r_cnt <= r_cnt - bfau_pkg::CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    if (r_dst == bfau_pkg::DST_P) begin
                        r_p <= n_acc;
                    end else begin
                        r_r <= n_acc;
                    end
                end
            end
        end
    end

endmodule

FILE: sv/bfau_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences operand loading, multiplier runs and result output.
// Depends on bfau_pkg.
module bfau_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_opcode,
    input  logic                          i_last_word,
    input  logic                          i_done,
    output bfau_pkg::t_cmd                o_cmd,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bfau_pkg::IDX_W-1:0]    o_out_idx,
    output logic                          o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_MUL,
        S_INV_START,
        S_INV_SQ,
        S_INV_MU,
        S_OUT
    } t_state;

    t_state                       r_state;
    bfau_pkg::t_cmd               r_cmd;
    bfau_pkg::t_cmd               n_cmd;
    logic [bfau_pkg::CNT_W-1:0]   r_k;
    logic [bfau_pkg::IDX_W-1:0]   r_idx;
    logic                         r_valid;

    localparam logic [bfau_pkg::IDX_W-1:0] LAST_IDX =
        bfau_pkg::IDX_W'(bfau_pkg::FIELD_WORDS - 1);

    assign o_ready   = (r_state == S_IDLE);
    assign o_cmd     = r_cmd;
    assign o_valid   = r_valid;
    assign o_out_idx = r_idx;
    assign o_last    = (r_idx == LAST_IDX);

    // Datapath command for the next cycle.
    always_comb begin
        n_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_last_word) begin
                    case (bfau_pkg::t_op'(i_opcode))
                        bfau_pkg::OP_ADD: begin
                            n_cmd.load_add = 1'b1;
                        end
                        bfau_pkg::OP_MUL: begin
                            n_cmd.start = 1'b1;
                            n_cmd.x_sel = bfau_pkg::SRC_A;
                            n_cmd.y_sel = bfau_pkg::SRC_B;
                            n_cmd.dst   = bfau_pkg::DST_R;
                        end
                        bfau_pkg::OP_SQR: begin
                            n_cmd.start = 1'b1;
                            n_cmd.x_sel = bfau_pkg::SRC_A;
                            n_cmd.y_sel = bfau_pkg::SRC_A;
                            n_cmd.dst   = bfau_pkg::DST_R;
                        end
                        default: begin
                            n_cmd.init_inv = 1'b1;
                        end
                    endcase
                end
            end
            S_INV_START: begin
                n_cmd.start = 1'b1;
                n_cmd.x_sel = bfau_pkg::SRC_P;
                n_cmd.y_sel = bfau_pkg::SRC_P;
                n_cmd.dst   = bfau_pkg::DST_P;
            end
            S_INV_SQ: begin
                if (i_done) begin
                    n_cmd.start = 1'b1;
                    n_cmd.x_sel = bfau_pkg::SRC_R;
                    n_cmd.y_sel = bfau_pkg::SRC_P;
                    n_cmd.dst   = bfau_pkg::DST_R;
                end
            end
            S_INV_MU: begin
                if (i_done && (r_k != '0)) begin
                    n_cmd.start = 1'b1;
                    n_cmd.x_sel = bfau_pkg::SRC_P;
                    n_cmd.y_sel = bfau_pkg::SRC_P;
                    n_cmd.dst   = bfau_pkg::DST_P;
                end
            end
            default: begin
                n_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= '0;
            r_k     <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cmd <= n_cmd;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && i_last_word) begin
                        case (bfau_pkg::t_op'(i_opcode))
                            bfau_pkg::OP_ADD: begin
                                r_state <= S_WAIT;
                            end
                            bfau_pkg::OP_MUL: begin
                                r_state <= S_MUL;
                            end
                            bfau_pkg::OP_SQR: begin
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_k     <= bfau_pkg::CNT_W'(bfau_pkg::FIELD_DEGREE - 2);
                                r_state <= S_INV_START;
                            end
                        endcase
                    end
                end
                S_WAIT: begin
                    r_idx   <= '0;
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_MUL: begin
                    if (i_done) begin
                        r_idx   <= '0;
                        r_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_INV_START: begin
                    r_state <= S_INV_SQ;
                end
                S_INV_SQ: begin
                    if (i_done) begin
                        r_state <= S_INV_MU;
                    end
                end
                S_INV_MU: begin
                    if (i_done) begin
                        if (r_k == '0) begin
                            r_idx   <= '0;
                            r_valid <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_k     <= r_k - bfau_pkg::CNT_W'(1);
                            r_state <= S_INV_SQ;
                        end
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (r_idx == LAST_IDX) begin
                            r_valid <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + bfau_pkg::IDX_W'(1);
                        end
                    end
                end
                default: begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: test/binary_field_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the GF(2^m) arithmetic unit: random operand streams,
// random handshake gaps and several modulus settings, checked against a built-in predictor.
// Depends on bfau_pkg and binary_field_arithmetic_unit.
module binary_field_arithmetic_unit_tb;

    // One operand word transaction as offered on the input channel.
    typedef struct {
        bfau_pkg::t_op                   op;
        logic [bfau_pkg::IDX_W-1:0]      idx;
        logic [bfau_pkg::WORD_W-1:0]     a;
        logic [bfau_pkg::WORD_W-1:0]     b;
        logic                            last;
    } t_operand_word;

    // One result word transaction as it should leave the block.
    typedef struct {
        logic [bfau_pkg::IDX_W-1:0]  idx;
        logic [bfau_pkg::WORD_W-1:0] word;
        logic                        last;
    } t_result_word;

    localparam int LONG_STALL_CYCLES = 400;
    localparam logic [bfau_pkg::FLAT_W-1:0] FIELD_MASK =
        {bfau_pkg::FLAT_W{1'b1}} >> (bfau_pkg::FLAT_W - bfau_pkg::FIELD_DEGREE);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Configuration port, driven only from the stimulus process while the unit is idle.
    logic                        cfg_we = 1'b0;
    logic [1:0]                  cfg_idx = '0;
    logic [bfau_pkg::WORD_W-1:0] cfg_data = '0;

    // Operand channel.
    logic                        op_valid = 1'b0;
    logic                        o_ready;
    logic [1:0]                  op_code = '0;
    logic [bfau_pkg::IDX_W-1:0]  op_word_index = '0;
    logic [bfau_pkg::WORD_W-1:0] op_a_word = '0;
    logic [bfau_pkg::WORD_W-1:0] op_b_word = '0;
    logic                        op_last = 1'b0;

    // Result channel.
    logic                        o_valid;
    logic                        res_ready = 1'b0;
    logic [bfau_pkg::IDX_W-1:0]  o_result_index;
    logic [bfau_pkg::WORD_W-1:0] o_result_word;
    logic                        o_result_last;

    // Predictor state: the modulus copy and the two operand stores.
    logic [bfau_pkg::MOD_W-1:0]  modulus_copy;
    logic [bfau_pkg::WORD_W-1:0] a_store [bfau_pkg::FIELD_WORDS];
    logic [bfau_pkg::WORD_W-1:0] b_store [bfau_pkg::FIELD_WORDS];

    t_operand_word pending_words[$];
    t_result_word  expected_words[$];
    int            error_count = 0;

    // Knobs set by the stimulus process, and the gap counters of the handshake processes.
    bit no_idle = 1'b0;
    bit long_stall_req = 1'b0;
    int long_stall_cnt = 0;
    int send_gap = 0;
    int recv_gap = 0;

    binary_field_arithmetic_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_valid        (op_valid),
        .o_ready        (o_ready),
        .i_opcode       (op_code),
        .i_word_index   (op_word_index),
        .i_a_word       (op_a_word),
        .i_b_word       (op_b_word),
        .i_last_word    (op_last),
        .o_valid        (o_valid),
        .i_ready        (res_ready),
        .o_result_index (o_result_index),
        .o_result_word  (o_result_word),
        .o_result_last  (o_result_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Field arithmetic used for prediction.
    // ------------------------------------------------------------------

    // Fold everything at and above degree m back through the low terms of the
    // modulus until nothing is left there. Each pass lowers the degree of the
    // high part, so the pass bound is only a guard.
    function automatic logic [bfau_pkg::FLAT_W-1:0] fold_product(
        input logic [2*bfau_pkg::FLAT_W-1:0] prod);
        logic [2*bfau_pkg::FLAT_W-1:0] high_part;
        for (int pass = 0; pass < 2 * bfau_pkg::FIELD_DEGREE + 8; pass++) begin
            high_part = (prod >> bfau_pkg::FIELD_DEGREE)
                        & {{bfau_pkg::FLAT_W{1'b0}}, {bfau_pkg::FLAT_W{1'b1}}};
            if (high_part == '0) break;
            prod = prod & {{bfau_pkg::FLAT_W{1'b0}}, FIELD_MASK};
            for (int e = 0; e < bfau_pkg::FIELD_DEGREE; e++) begin
                if (modulus_copy[e]) prod = prod ^ (high_part << e);
            end
        end
        return prod[bfau_pkg::FLAT_W-1:0] & FIELD_MASK;
    endfunction

    function automatic logic [bfau_pkg::FLAT_W-1:0] gf_mul(
        input logic [bfau_pkg::FLAT_W-1:0] x,
        input logic [bfau_pkg::FLAT_W-1:0] y);
        logic [2*bfau_pkg::FLAT_W-1:0] prod;
        prod = '0;
        for (int i = 0; i < bfau_pkg::FIELD_DEGREE; i++) begin
            if (x[i]) prod = prod ^ ({{bfau_pkg::FLAT_W{1'b0}}, y} << i);
        end
        return fold_product(prod);
    endfunction

    // Squaring spreads bit i of the operand to bit 2i before the fold.
    function automatic logic [bfau_pkg::FLAT_W-1:0] gf_square(
        input logic [bfau_pkg::FLAT_W-1:0] x);
        logic [2*bfau_pkg::FLAT_W-1:0] prod;
        prod = '0;
        for (int i = 0; i < bfau_pkg::FLAT_W; i++) prod[2*i] = x[i];
        return fold_product(prod);
    endfunction

    // Itoh-Tsujii: build x^(2^(m-1)-1) by doubling chains, then square once.
    // The inverse of zero is zero.
    function automatic logic [bfau_pkg::FLAT_W-1:0] gf_invert(
        input logic [bfau_pkg::FLAT_W-1:0] x);
        logic [bfau_pkg::FLAT_W-1:0] acc;
        logic [bfau_pkg::FLAT_W-1:0] pw;
        int exp_target;
        int top_bit;
        int chain;
        if (x == '0) return '0;
        exp_target = bfau_pkg::FIELD_DEGREE - 1;
        top_bit = 0;
        for (int v = exp_target; v > 1; v = v >> 1) top_bit++;
        chain = 1;
        acc = x;
        for (int bit_pos = top_bit - 1; bit_pos >= 0; bit_pos--) begin
            pw = acc;
            for (int i = 0; i < chain; i++) pw = gf_square(pw);
            acc = gf_mul(pw, acc);
            chain = chain * 2;
            if ((exp_target >> bit_pos) & 1) begin
                acc = gf_square(acc);
                acc = gf_mul(acc, x);
                chain++;
            end
        end
        return gf_square(acc);
    endfunction

    // Store the operand words of an accepted transaction and, on the last word,
    // queue the result words of the selected operation.
    function automatic void predict_operation(input t_operand_word w);
        logic [bfau_pkg::FLAT_W-1:0] flat_a;
        logic [bfau_pkg::FLAT_W-1:0] flat_b;
        logic [bfau_pkg::FLAT_W-1:0] outcome;
        logic [bfau_pkg::FLAT_W-1:0] lane_mask;
        t_result_word rw;
        lane_mask = FIELD_MASK >> (bfau_pkg::WORD_W * int'(w.idx));
        if (int'(w.idx) < bfau_pkg::FIELD_WORDS) begin
            a_store[w.idx] = w.a & lane_mask[bfau_pkg::WORD_W-1:0];
            b_store[w.idx] = w.b & lane_mask[bfau_pkg::WORD_W-1:0];
        end
        if (!w.last) return;
        for (int i = 0; i < bfau_pkg::FIELD_WORDS; i++) begin
            flat_a[bfau_pkg::WORD_W*i +: bfau_pkg::WORD_W] = a_store[i];
            flat_b[bfau_pkg::WORD_W*i +: bfau_pkg::WORD_W] = b_store[i];
        end
        case (w.op)
            bfau_pkg::OP_ADD: outcome = (flat_a ^ flat_b) & FIELD_MASK;
            bfau_pkg::OP_MUL: outcome = gf_mul(flat_a, flat_b);
            bfau_pkg::OP_SQR: outcome = gf_square(flat_a);
            default:          outcome = gf_invert(flat_a);
        endcase
        for (int i = 0; i < bfau_pkg::FIELD_WORDS; i++) begin
            rw.idx  = bfau_pkg::IDX_W'(i);
            rw.word = outcome[bfau_pkg::WORD_W*i +: bfau_pkg::WORD_W];
            rw.last = (i == bfau_pkg::FIELD_WORDS - 1);
            expected_words.push_back(rw);
        end
    endfunction

    // Mostly back-to-back, sometimes a short pause, now and then a long one; no pause when no_idle is set.
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued operand words, holding each until accepted.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_operand_word w;
        if (!i_rst_n) begin
            op_valid <= 1'b0;
            send_gap <= 0;
        end else if (!op_valid || o_ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                op_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                op_code       <= w.op;
                op_word_index <= w.idx;
                op_a_word     <= w.a;
                op_b_word     <= w.b;
                op_last       <= w.last;
                op_valid      <= 1'b1;
                send_gap      <= pick_gap();
            end else begin
                op_valid <= 1'b0;
            end
        end
    end

    // Input monitor: every accepted transaction goes through the predictor.
    always @(posedge i_clk) begin
        t_operand_word w;
        if (i_rst_n && op_valid && o_ready) begin
            w.op   = bfau_pkg::t_op'(op_code);
            w.idx  = op_word_index;
            w.a    = op_a_word;
            w.b    = op_b_word;
            w.last = op_last;
            predict_operation(w);
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random ready gaps, plus one long hold-off on request so the
    // unit backs up and stops taking operand words.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
            recv_gap <= 0;
        end else if (long_stall_req && long_stall_cnt < LONG_STALL_CYCLES) begin
            long_stall_cnt <= long_stall_cnt + 1;
            res_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            res_ready <= 1'b0;
        end else begin
            res_ready <= 1'b1;
            if (o_valid && res_ready) recv_gap <= pick_gap();
        end
    end

    // Output monitor: each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_result_word ew;
        if (i_rst_n && o_valid && res_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result idx=%0d word=%h last=%0b", $time,
                         o_result_index, o_result_word, o_result_last);
                error_count++;
            end else begin
                ew = expected_words.pop_front();
                if (o_result_index !== ew.idx) begin
                    $display("%0t: result_index expected %0d actual %0d", $time,
                             ew.idx, o_result_index);
                    error_count++;
                end
                if (o_result_word !== ew.word) begin
                    $display("%0t: result_word expected %h actual %h", $time,
                             ew.word, o_result_word);
                    error_count++;
                end
                if (o_result_last !== ew.last) begin
                    $display("%0t: result_last expected %0b actual %0b", $time,
                             ew.last, o_result_last);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Random operand word with a bias toward the all-zero and all-one extremes.
    function automatic logic [bfau_pkg::WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom(), $urandom()};
    endfunction

    // Queue one operation: either a full load of words 0..3 or a few words at
    // random positions (the stores already hold earlier values), ending on the
    // last word that carries the opcode.
    task automatic queue_operation(input bfau_pkg::t_op op, input bit full_load);
        t_operand_word w;
        int n_words;
        n_words = full_load ? bfau_pkg::FIELD_WORDS
                            : $urandom_range(1, bfau_pkg::FIELD_WORDS);
        for (int i = 0; i < n_words; i++) begin
            w.op   = bfau_pkg::t_op'($urandom_range(0, 3));
            w.idx  = full_load ? bfau_pkg::IDX_W'(i)
                               : bfau_pkg::IDX_W'($urandom_range(0, bfau_pkg::FIELD_WORDS - 1));
            w.a    = pick_word();
            w.b    = pick_word();
            w.last = (i == n_words - 1);
            if (w.last) w.op = op;
            pending_words.push_back(w);
        end
    endtask

    // Queue a full load of fixed values followed by the given operation.
    task automatic queue_fixed(input bfau_pkg::t_op op,
                               input logic [bfau_pkg::FLAT_W-1:0] a_val,
                               input logic [bfau_pkg::FLAT_W-1:0] b_val);
        t_operand_word w;
        for (int i = 0; i < bfau_pkg::FIELD_WORDS; i++) begin
            w.op   = op;
            w.idx  = bfau_pkg::IDX_W'(i);
            w.a    = a_val[bfau_pkg::WORD_W*i +: bfau_pkg::WORD_W];
            w.b    = b_val[bfau_pkg::WORD_W*i +: bfau_pkg::WORD_W];
            w.last = (i == bfau_pkg::FIELD_WORDS - 1);
            pending_words.push_back(w);
        end
    endtask

    // Random operations other than invert, which is far too slow for bulk use.
    task automatic queue_random_ops(input int n_items);
        int start_size;
        start_size = pending_words.size();
        while (pending_words.size() - start_size < n_items) begin
            queue_operation(bfau_pkg::t_op'($urandom_range(0, 2)), $urandom_range(0, 7) == 0);
        end
    endtask

    // Let every queued word go in and every expected result come out, then
    // let the unit idle before the next configuration change.
    task automatic drain_unit();
        while (pending_words.size() > 0 || op_valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_modulus(input logic [bfau_pkg::MOD_W-1:0] value);
        for (int i = 0; i < bfau_pkg::MOD_REGS; i++) begin
            @(posedge i_clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= 2'(i);
            cfg_data <= value[bfau_pkg::WORD_W*i +: bfau_pkg::WORD_W];
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
        modulus_copy = value;
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        logic [bfau_pkg::MOD_W-1:0] random_mod;
        modulus_copy = '0;
        modulus_copy[bfau_pkg::WORD_W-1:0] = bfau_pkg::MOD_RESET0;
        for (int i = 0; i < bfau_pkg::FIELD_WORDS; i++) begin
            a_store[i] = '0;
            b_store[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset modulus. The first operation loads every word so that no
        // store is read before it has been written.
        queue_fixed(bfau_pkg::OP_ADD, '0, '1);
        queue_fixed(bfau_pkg::OP_MUL, '1, '1);
        queue_fixed(bfau_pkg::OP_SQR, '1, '0);
        queue_fixed(bfau_pkg::OP_MUL, bfau_pkg::FLAT_W'(1),
                    {$urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom()});
        queue_fixed(bfau_pkg::OP_INV, '0, '1);
        queue_fixed(bfau_pkg::OP_INV, bfau_pkg::FLAT_W'(1), '0);
        queue_random_ops(100);
        drain_unit();

        // All-ones modulus: the fold needs many passes to settle.
        write_modulus('1);
        queue_random_ops(100);
        drain_unit();

        // Bare x^m: the fold just drops the high part. No idling here.
        no_idle = 1'b1;
        write_modulus('0);
        queue_random_ops(100);
        drain_unit();
        no_idle = 1'b0;

        // Random modulus, with the receiver held off at the start while the
        // sender keeps offering words.
        for (int i = 0; i < bfau_pkg::MOD_REGS; i++)
            random_mod[bfau_pkg::WORD_W*i +: bfau_pkg::WORD_W] = {$urandom(), $urandom()};
        write_modulus(random_mod);
        long_stall_req = 1'b1;
        queue_random_ops(100);
        drain_unit();

        // Back to the standard pentanomial, one random invert included.
        random_mod = '0;
        random_mod[bfau_pkg::WORD_W-1:0] = bfau_pkg::MOD_RESET0;
        write_modulus(random_mod);
        queue_random_ops(40);
        queue_operation(bfau_pkg::OP_INV, 1'b0);
        queue_random_ops(40);
        drain_unit();

        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Three inversions dominate the run; this leaves ample margin.
    initial begin
        #60ms;
        $display("FAIL");
        $finish;
    end

endmodule
